### sv/dqpwm_pkg.sv
package dqpwm_pkg;

   // Field and register widths
   localparam int VOLT_W    = 16;
   localparam int ANGLE_W   = 16;
   localparam int DUTY_W    = 16;
   localparam int CSR_W     = 15;
   localparam int CSR_IDX_W = 1;
   localparam int PHASES    = 3;

   // Signed sine sample (Q1.15) and its magnitude
   localparam int SINE_W     = 16;
   localparam int SINE_MAG_W = SINE_W - 1;

   // Datapath widths
   localparam int PROD_W    = 2 * SINE_W;
   localparam int VSUM_W    = PROD_W + 1;
   localparam int MAG_W     = 2 * CSR_W;
   localparam int NUM_W     = 2 * CSR_W;
   localparam int SCALE_W   = MAG_W + CSR_W;
   localparam int DIV_STEPS = CSR_W;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_SUPPLY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_HALF   = 1'b1;

   localparam logic [CSR_W-1:0] HALF_SUPPLY_RST = 15'd12288;
   localparam logic [CSR_W-1:0] DUTY_HALF_RST   = 15'd500;

   // 120 degrees of a 16-bit turn, rounded
   localparam logic [ANGLE_W-1:0] THIRD_TURN = 16'd21845;

   // Angle offset of phases A, B (minus 120) and C (plus 120)
   localparam logic [ANGLE_W-1:0] PHASE_OFS [PHASES] = '{
      16'd0, 16'd43691, THIRD_TURN
   };

   typedef struct packed {
      logic signed [VOLT_W-1:0] volt_d;
      logic signed [VOLT_W-1:0] volt_q;
      logic [ANGLE_W-1:0]       elec_angle;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_phase_a;
      logic [DUTY_W-1:0] duty_phase_b;
      logic [DUTY_W-1:0] duty_phase_c;
   } rsp_type;

   // First-quarter sine sample k of a 2^bits table, Q15, from a Taylor
   // series in Q30; evaluated at elaboration only.
   function automatic logic [SINE_MAG_W-1:0] quarter_sine(input int unsigned k,
                                                           input int unsigned bits);
      longint unsigned th;
      longint unsigned term;
      longint          sum;
      th   = (64'd6746518852 * longint'(k)) >> bits;
      term = th;
      sum  = longint'(th);
      for (int unsigned n = 1; n <= 7; n++) begin
         term = (term * th) >> 30;
         term = (term * th) >> 30;
         // divide by (2n)(2n+1)
         unique case (n)
            1: term = term / 64'd6;
            2: term = term / 64'd20;
            3: term = term / 64'd42;
            4: term = term / 64'd72;
            5: term = term / 64'd110;
            6: term = term / 64'd156;
            default: term = term / 64'd210;
         endcase
         if (n[0]) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         return '0;
      end
      sum = (sum + 16384) >>> 15;
      if (sum > 32767) begin
         sum = 32767;
      end
      return sum[SINE_MAG_W-1:0];
   endfunction

endpackage

### sv/dq_to_three_phase_pwm_duty.sv
// Inverse Park/Clarke sinusoidal PWM: each beat on req_ carries a d/q voltage
// pair (signed Q4.11) and a 16-bit electrical angle; the block returns one
// beat on rsp_ with the three timer compare values for phases A, B (angle
// minus 120 deg) and C (angle plus 120 deg). Each phase voltage
// cos*volt_d - sin*volt_q is clamped to +-half_supply, scaled by
// duty_half/half_supply (truncated toward zero) and offset by duty_half, so
// every compare value lies in 0 .. 2*duty_half; half_supply of zero gives
// duty_half on all phases. The pipeline takes one beat per clock while
// rsp_ready is high; its stages are table lookup, two multiplies, clamp,
// scale multiply, a 15-stage restoring divider (one quotient bit per stage,
// the deepest part of the pipeline) and the output register. Stages hold
// their beat when the one ahead is full and stalled, so bubbles close up and
// req_ready stays high while a finished result waits on rsp_ready, until
// every stage holds a beat. Write half_supply (index 0) and duty_half
// (index 1) through csr_ only while the pipeline is empty.
module dq_to_three_phase_pwm_duty #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  dqpwm_pkg::req_type                     req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output dqpwm_pkg::rsp_type                     rsp_data,
   input  logic                                   csr_we,
   input  logic [dqpwm_pkg::CSR_IDX_W-1:0]        csr_idx,
   input  logic [dqpwm_pkg::CSR_W-1:0]            csr_wdata
);

   localparam int STB = SINE_TABLE_BITS;
   localparam int KW  = STB - 2;
   localparam int QN  = 2 ** KW;

   localparam int CW  = dqpwm_pkg::CSR_W;
   localparam int NW  = dqpwm_pkg::NUM_W;
   localparam int MW  = dqpwm_pkg::MAG_W;
   localparam int SW  = dqpwm_pkg::SINE_W;
   localparam int PW  = dqpwm_pkg::PROD_W;
   localparam int VW  = dqpwm_pkg::VSUM_W;
   localparam int XW  = dqpwm_pkg::SCALE_W;
   localparam int DW  = dqpwm_pkg::DUTY_W;
   localparam int NPH = dqpwm_pkg::PHASES;
   localparam int NDV = dqpwm_pkg::DIV_STEPS;

   // Pipeline stage positions
   localparam int ST_LOOK  = 0;
   localparam int ST_MUL   = 1;
   localparam int ST_CLAMP = 2;
   localparam int ST_SCALE = 3;
   localparam int ST_DIV0  = 4;
   localparam int ST_OUT   = ST_DIV0 + NDV;
   localparam int NSTG     = ST_OUT + 1;

   typedef logic [dqpwm_pkg::SINE_MAG_W-1:0] qtab_type [QN];

   function automatic qtab_type build_tab();
      qtab_type t;
      for (int unsigned k = 0; k < QN; k++) begin
         t[k] = dqpwm_pkg::quarter_sine(k, STB);
      end
      return t;
   endfunction

   localparam qtab_type QUARTER_TAB = build_tab();
   // Sample at exactly a quarter turn, reached by the mirrored quadrants
   localparam logic [dqpwm_pkg::SINE_MAG_W-1:0] QTOP =
      dqpwm_pkg::quarter_sine(QN, STB);

   // Full-turn sine from the quarter table: mirror odd quadrants, negate
   // the lower half-turn.
   function automatic logic signed [SW-1:0] sine_at(input logic [STB-1:0] idx);
      logic [1:0]                           quad;
      logic [KW-1:0]                        k;
      logic [KW-1:0]                        kk;
      logic [dqpwm_pkg::SINE_MAG_W-1:0]     m;
      quad = idx[STB-1 -: 2];
      k    = idx[KW-1:0];
      kk   = quad[0] ? KW'(KW'(0) - k) : k;
      if (quad[0] && (k == '0)) begin
         m = QTOP;
      end else begin
         m = QUARTER_TAB[kk];
      end
      if (quad[1]) begin
         return -$signed({1'b0, m});
      end
      return $signed({1'b0, m});
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [CW-1:0] half_supply_ff, half_supply_in;
   logic [CW-1:0] duty_half_ff, duty_half_in;

   always_comb begin
      half_supply_in = half_supply_ff;
      duty_half_in   = duty_half_ff;
      if (csr_we) begin
         unique case (csr_idx)
            dqpwm_pkg::CSR_HALF_SUPPLY: half_supply_in = csr_wdata;
            dqpwm_pkg::CSR_DUTY_HALF:   duty_half_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_supply_ff <= dqpwm_pkg::HALF_SUPPLY_RST;
         duty_half_ff   <= dqpwm_pkg::DUTY_HALF_RST;
      end else begin
         half_supply_ff <= half_supply_in;
         duty_half_ff   <= duty_half_in;
      end
   end

   // ---------------------------------------------------------------------
   // Flow control: a stage loads when it is empty or the stage ahead moves
   // ---------------------------------------------------------------------
   logic [NSTG-1:0] vld_ff, vld_in;
   logic [NSTG-1:0] en;

   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || rsp_ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in = (vld_ff & ~en) | ({vld_ff[NSTG-2:0], req_valid} & en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = en[ST_LOOK];

   // ---------------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------------
   logic signed [SW-1:0] ud_ff, uq_ff;
   logic signed [SW-1:0] sin_ff [NPH];
   logic signed [SW-1:0] cos_ff [NPH];
   logic signed [SW-1:0] sin_in [NPH];
   logic signed [SW-1:0] cos_in [NPH];

   logic signed [PW-1:0] pc_ff [NPH];
   logic signed [PW-1:0] ps_ff [NPH];

   logic [MW-1:0]        mag_ff [NPH];
   logic [MW-1:0]        mag_in [NPH];
   logic [NPH-1:0]       neg3_ff, neg3_in;

   logic [NW-1:0]        num_ff [NPH];
   logic [NW-1:0]        num_in [NPH];
   logic [NPH-1:0]       neg4_ff;

   logic [NW-1:0]        work_ff [NDV][NPH];
   logic [NW-1:0]        work_in [NDV][NPH];
   logic [NPH-1:0]       dneg_ff [NDV];

   logic [DW-1:0]        duty_in [NPH];
   dqpwm_pkg::rsp_type   rsp_ff;

   logic [MW-1:0]        lim;
   assign lim = {half_supply_ff, CW'(0)};

   for (genvar p = 0; p < NPH; p++) begin : g_phase
      logic [dqpwm_pkg::ANGLE_W-1:0] ang;
      logic [STB-1:0]                idx_s;
      logic [STB-1:0]                idx_c;
      logic signed [VW-1:0]          vsum;
      logic [VW-1:0]                 absv;
      logic [XW-1:0]                 scaled;
      logic [CW-1:0]                 quot;

      // Lookup: shift the angle per phase, cosine is a quarter turn ahead
      assign ang     = req_data.elec_angle + dqpwm_pkg::PHASE_OFS[p];
      assign idx_s   = ang[dqpwm_pkg::ANGLE_W-1 -: STB];
      assign idx_c   = idx_s + STB'(QN);
      assign sin_in[p] = sine_at(idx_s);
      assign cos_in[p] = sine_at(idx_c);

      // Clamp: magnitude of the phase voltage, limited to half_supply
      assign vsum       = VW'(pc_ff[p]) - VW'(ps_ff[p]);
      assign neg3_in[p] = vsum[VW-1];
      assign absv       = vsum[VW-1] ? VW'(-vsum) : VW'(vsum);
      assign mag_in[p]  = (absv > VW'(lim)) ? lim : absv[MW-1:0];

      // Scale: numerator of the divide, already reduced by 2^15
      assign scaled     = XW'(mag_ff[p]) * XW'(duty_half_ff);
      assign num_in[p]  = scaled[XW-1 -: NW];

      // Restoring divide by half_supply, one quotient bit per stage.
      // High half holds the remainder, low half shifts numerator bits out
      // and quotient bits in.
      for (genvar j = 0; j < NDV; j++) begin : g_div
         logic [NW-1:0] src;
         logic [CW:0]   trial;
         logic          take;
         logic [CW-1:0] rem;
         if (j == 0) begin : g_first
            assign src = num_ff[p];
         end else begin : g_next
            assign src = work_ff[j-1][p];
         end
         assign trial = {src[NW-1:CW], src[CW-1]};
         assign take  = trial >= {1'b0, half_supply_ff};
         assign rem   = take ? CW'(trial - {1'b0, half_supply_ff}) : trial[CW-1:0];
         assign work_in[j][p] = {rem, src[CW-2:0], take};
      end

      // Output: offset the signed quotient by duty_half
      assign quot = work_ff[NDV-1][p][CW-1:0];
      assign duty_in[p] = (half_supply_ff == '0) ? DW'(duty_half_ff) :
                          dneg_ff[NDV-1][p]      ? DW'(duty_half_ff) - DW'(quot) :
                                                   DW'(duty_half_ff) + DW'(quot);
   end

   always_ff @(posedge clock) begin
      if (en[ST_LOOK]) begin
         ud_ff  <= req_data.volt_d;
         uq_ff  <= req_data.volt_q;
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
      if (en[ST_MUL]) begin
         for (int p = 0; p < NPH; p++) begin
            pc_ff[p] <= PW'(cos_ff[p]) * PW'(ud_ff);
            ps_ff[p] <= PW'(sin_ff[p]) * PW'(uq_ff);
         end
      end
      if (en[ST_CLAMP]) begin
         mag_ff  <= mag_in;
         neg3_ff <= neg3_in;
      end
      if (en[ST_SCALE]) begin
         num_ff  <= num_in;
         neg4_ff <= neg3_ff;
      end
      for (int j = 0; j < NDV; j++) begin
         if (en[ST_DIV0 + j]) begin
            work_ff[j] <= work_in[j];
            dneg_ff[j] <= (j == 0) ? neg4_ff : dneg_ff[(j == 0) ? 0 : j - 1];
         end
      end
      if (en[ST_OUT]) begin
         rsp_ff.duty_phase_a <= duty_in[0];
         rsp_ff.duty_phase_b <= duty_in[1];
         rsp_ff.duty_phase_c <= duty_in[2];
      end
   end

   assign rsp_valid = vld_ff[ST_OUT];
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // Input blocks only when every stage is full and the output is stalled
   a_block_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> ((&vld_ff) && !rsp_ready))
      else $error("req_ready low with a free pipeline stage");

   // A held beat in the first stage is never dropped
   a_hold_first_stage: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[ST_LOOK] && !en[ST_LOOK]) |=> vld_ff[ST_LOOK])
      else $error("stalled beat lost in lookup stage");

   // Output drains when nothing follows the delivered beat
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !vld_ff[ST_OUT-1]) |=> !rsp_valid)
      else $error("result repeated after delivery");

endmodule
